/* hw/rtl/gsg_pkg.sv */
// Shared types, constants and the gray weighting for the Sobel gradient block.
// No dependencies; gsg_sobel, the top level and the bench import this package.
package gsg_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);     // 11
    localparam int ROW_W      = $clog2(MAX_HEIGHT);    // 12
    localparam int FW_W       = 12;                    // frame_width register
    localparam int FH_W       = 13;                    // frame_height register
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = 11;                    // signed Sobel sum, +-1020

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);
    localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [ROW_W-1:0] pix_row;
        logic [COL_W-1:0] pix_col;
        logic [7:0]       gray;
        logic [7:0]       grad_x;
        logic [7:0]       grad_y;
        logic             last_of_run;
    } res_t;

    // columns c-2 and c-1 of the 3x3 window, three rows each
    typedef struct packed {
        logic [7:0] tl;
        logic [7:0] ml;
        logic [7:0] bl;
        logic [7:0] tc;
        logic [7:0] mc;
        logic [7:0] bc;
    } window_t;

    function automatic logic [7:0] gray_of(input pix_t p);
        logic [17:0] acc;
        acc = 18'd306 * 18'(p.red) + 18'd601 * 18'(p.green) + 18'd117 * 18'(p.blue);
        return acc[17:10];
    endfunction

endpackage

/* hw/rtl/gsg_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/gsg_sobel.sv */
// 3x3 Sobel X/Y kernel: sums, divide by 4 toward zero, keep the low 8 bits.
// Depends on gsg_pkg for the window type.
module gsg_sobel
    import gsg_pkg::*;
(
    input  window_t    win,
    input  logic [7:0] tr,
    input  logic [7:0] mr,
    input  logic [7:0] br,
    output logic [7:0] grad_x,
    output logic [7:0] grad_y
);

    function automatic logic [7:0] div4_wrap(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        // arithmetic shift floors; bias negatives by 3 to truncate toward zero
        if (s < 0)
        begin
            q = (s + SUM_W'(signed'(3))) >>> 2;
        end
        else
        begin
            q = s >>> 2;
        end
        return q[7:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic [7:0] v);
        return signed'({{(SUM_W-8){1'b0}}, v});
    endfunction

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    always_comb
    begin
        sum_x = ext(tr) - ext(win.tl) + ((ext(mr) - ext(win.ml)) <<< 1)
              + ext(br) - ext(win.bl);
        sum_y = ext(win.bl) + (ext(win.bc) <<< 1) + ext(br)
              - ext(win.tl) - (ext(win.tc) <<< 1) - ext(tr);
        grad_x = div4_wrap(sum_x);
        grad_y = div4_wrap(sum_y);
    end

endmodule

/* hw/rtl/gray_sobel_gradient.sv */
// Top level of the streaming gray-level Sobel gradient block.
// Depends on gsg_pkg, gsg_ram (two line stores) and gsg_sobel.
//
// RGB pixels arrive in raster order on the pix channel, one item per clock at
// best. Each is weighted to gray and held in two line stores; pixels of the middle
// rows come out one row and one column late with their Sobel X/Y gradients
// (sum / 4 toward zero, low 8 bits), border pixels come out with their own gray as
// both gradients, and first/last rows come out as they arrive. One pixel yields 0
// to 3 results and the single output register passes one result per clock while
// res_stall is low, so a pixel with more than one result stalls the input until
// its last result is loaded: two at the end of each row from row 2 on and for
// every pixel of the bottom row but its first, three at the last pixel of the frame.
// Results leave through the output register. frame_width is clamped to 3..2048
// and frame_height to 3..4096; write them only while the block is idle (a change
// inside a frame keeps the current position).
module gray_sobel_gradient
    import gsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_t                  pix,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // effective (clamped) frame size
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [FW_W-1:0]  width_clamp;
    logic [FH_W-1:0]  height_clamp;

    // position of the next pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // input stage
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [ROW_W-1:0] s1_row_up_reg;
    logic [7:0]       s1_gray_reg;
    logic             s1_first_col_reg;     // c == 1: left border of the row above
    logic [2:0]       s1_kind_reg;          // [0] lagged, [1] right border, [2] own
    logic [2:0]       s1_done_reg, s1_done_next;

    logic [7:0]       line_top;
    logic [7:0]       line_mid;
    window_t          win_reg;

    res_t             res_reg;
    logic             res_valid_reg;

    logic             accept;
    logic             load_ok;
    logic             emit;
    logic             s1_fire;
    logic [2:0]       avail;
    logic [2:0]       cur;
    logic [2:0]       rest;
    res_t             res_cur;
    logic [7:0]       grad_x;
    logic [7:0]       grad_y;

    // position bookkeeping at accept
    logic [FW_W-1:0]  c_wide;
    logic [FH_W-1:0]  r_wide;
    logic [COL_W-1:0] c_now;
    logic [ROW_W-1:0] r_now;
    logic [FW_W-1:0]  c_inc;
    logic [FH_W-1:0]  r_inc;
    logic             kind_lag;
    logic             kind_right;
    logic             kind_own;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (FW_W'(cfg_data) < FW_MIN)
        begin
            width_clamp = FW_MIN;
        end
        else if (FW_W'(cfg_data) > FW_MAX)
        begin
            width_clamp = FW_MAX;
        end
        else
        begin
            width_clamp = FW_W'(cfg_data);
        end
        if (FH_W'(cfg_data) < FH_MIN)
        begin
            height_clamp = FH_MIN;
        end
        else if (FH_W'(cfg_data) > FH_MAX)
        begin
            height_clamp = FH_MAX;
        end
        else
        begin
            height_clamp = FH_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_RESET;
            height_reg <= FH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= width_clamp;
                CFG_FRAME_HEIGHT: height_reg <= height_clamp;
            endcase
        end
    end

    // handshake between stage 1 and the output register
    always_comb
    begin
        avail   = s1_kind_reg & ~s1_done_reg;
        cur     = avail & (~avail + 3'd1);          // lowest pending result
        rest    = avail & ~cur;
        load_ok = !res_valid_reg || !res_stall;
        emit    = s1_valid_reg && (avail != 3'b000) && load_ok;
        s1_fire = s1_valid_reg && ((avail == 3'b000) || (load_ok && rest == 3'b000));
        pix_stall = s1_valid_reg && !s1_fire;
        accept  = pix_valid && !pix_stall;

        if (s1_fire)
        begin
            s1_done_next = 3'b000;
        end
        else if (emit)
        begin
            s1_done_next = s1_done_reg | cur;
        end
        else
        begin
            s1_done_next = s1_done_reg;
        end
    end

    // where the arriving pixel lands and where the next one will
    always_comb
    begin
        if ({1'b0, col_reg} >= width_reg)
        begin
            c_now  = '0;
            r_wide = {1'b0, row_reg} + FH_W'(1);
        end
        else
        begin
            c_now  = col_reg;
            r_wide = {1'b0, row_reg};
        end
        if (r_wide >= height_reg)
        begin
            r_now = '0;
        end
        else
        begin
            r_now = r_wide[ROW_W-1:0];
        end
        c_wide = {1'b0, c_now};

        kind_lag   = (r_now >= ROW_W'(2)) && (c_now != '0);
        kind_right = kind_lag && (c_wide == width_reg - FW_W'(1));
        kind_own   = (r_now == '0) || ({1'b0, r_now} == height_reg - FH_W'(1));

        c_inc = c_wide + FW_W'(1);
        r_inc = {1'b0, r_now} + FH_W'(1);
        if (c_inc >= width_reg)
        begin
            col_next = '0;
            if (r_inc >= height_reg)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = r_inc[ROW_W-1:0];
            end
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_done_reg   <= 3'b000;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_done_reg <= s1_done_next;
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= c_now;
            s1_row_reg       <= r_now;
            s1_row_up_reg    <= r_now - ROW_W'(1);
            s1_gray_reg      <= gray_of(pix);
            s1_first_col_reg <= (c_now == COL_W'(1));
            s1_kind_reg      <= {kind_own, kind_right, kind_lag};
        end
        if (s1_fire)
        begin
            win_reg.tl <= win_reg.tc;
            win_reg.ml <= win_reg.mc;
            win_reg.bl <= win_reg.bc;
            win_reg.tc <= line_top;
            win_reg.mc <= line_mid;
            win_reg.bc <= s1_gray_reg;
        end
        if (emit)
        begin
            res_reg <= res_cur;
        end
    end

    // row r-2 and row r-1 per column
    gsg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_older (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (line_mid),
        .rd_en   (accept),
        .rd_addr (c_now),
        .rd_data (line_top)
    );

    gsg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_newer (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (s1_gray_reg),
        .rd_en   (accept),
        .rd_addr (c_now),
        .rd_data (line_mid)
    );

    gsg_sobel u_sobel (
        .win    (win_reg),
        .tr     (line_top),
        .mr     (line_mid),
        .br     (s1_gray_reg),
        .grad_x (grad_x),
        .grad_y (grad_y)
    );

    // pick the pending result in order: lagged pixel, right border, own row
    always_comb
    begin
        res_cur.last_of_run = (rest == 3'b000);
        priority if (cur[0])
        begin
            res_cur.pix_row = s1_row_up_reg;
            res_cur.gray    = win_reg.mc;
            if (s1_first_col_reg)
            begin
                res_cur.pix_col = '0;
                res_cur.grad_x  = win_reg.mc;
                res_cur.grad_y  = win_reg.mc;
            end
            else
            begin
                res_cur.pix_col = s1_col_reg - COL_W'(1);
                res_cur.grad_x  = grad_x;
                res_cur.grad_y  = grad_y;
            end
        end
        else if (cur[1])
        begin
            res_cur.pix_row = s1_row_up_reg;
            res_cur.pix_col = s1_col_reg;
            res_cur.gray    = line_mid;
            res_cur.grad_x  = line_mid;
            res_cur.grad_y  = line_mid;
        end
        else
        begin
            res_cur.pix_row = s1_row_reg;
            res_cur.pix_col = s1_col_reg;
            res_cur.gray    = s1_gray_reg;
            res_cur.grad_x  = s1_gray_reg;
            res_cur.grad_y  = s1_gray_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* tb/gray_sobel_gradient_tb.sv */
// Self-checking bench for gray_sobel_gradient: directed table then random frames.
// Depends on gsg_pkg and the block's RTL; results are checked against a local model.
module gray_sobel_gradient_tb;
    import gsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_GAP   = 8;        // cycles a result-free item may still be inside
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 65;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_WIDTH,
        STEP_HEIGHT
    } step_kind_t;

    typedef struct {
        step_kind_t            kind;
        pix_t                  px;
        logic [CFG_DATA_W-1:0] value;
        bit                    typed;
        res_t                  want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    pix_t                  pix = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b1;
    res_t                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int pixels_sent = 0;

    // local copy of the block's registers and state
    logic [FW_W-1:0] fw_set = FW_RESET;
    logic [FH_W-1:0] fh_set = FH_RESET;
    int              pos_col = 0;
    int              pos_row = 0;
    logic [7:0]      line_old [MAX_WIDTH];
    logic [7:0]      line_new [MAX_WIDTH];
    window_t         win = '0;

    res_t  step_results[$];
    res_t  results_due[$];
    step_t plan [23];

    gray_sobel_gradient u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    task automatic report_mismatch(input string msg);
        // cap the log; the count still decides the verdict
        if (mismatch_count < 40)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic int frame_w();
        if (fw_set < FW_MIN)
            return FW_MIN;
        if (fw_set > FW_MAX)
            return FW_MAX;
        return fw_set;
    endfunction

    function automatic int frame_h();
        if (fh_set < FH_MIN)
            return FH_MIN;
        if (fh_set > FH_MAX)
            return FH_MAX;
        return fh_set;
    endfunction

    function automatic res_t border_res(input int row, input int col, input int lvl);
        res_t o;
        o             = '0;
        o.pix_row     = ROW_W'(row);
        o.pix_col     = COL_W'(col);
        o.gray        = 8'(lvl);
        o.grad_x      = 8'(lvl);
        o.grad_y      = 8'(lvl);
        return o;
    endfunction

    // One pixel into the local model; its results land in step_results.
    task automatic sobel_predict(input pix_t p);
        int   w;
        int   h;
        int   r;
        int   c;
        int   lvl;
        int   above2;
        int   above1;
        int   tl;
        int   ml;
        int   bl;
        int   tc;
        int   bc;
        int   sx;
        int   sy;
        res_t o;
        step_results = {};
        w = frame_w();
        h = frame_h();
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h)
            pos_row = 0;
        r = pos_row;
        c = pos_col;
        lvl = (306 * p.red + 601 * p.green + 117 * p.blue) >> 10;
        above2 = line_old[c];
        above1 = line_new[c];
        line_old[c] = line_new[c];
        line_new[c] = 8'(lvl);

        if (r >= 2 && c >= 1)
        begin
            if (c == 1)
                step_results.push_back(border_res(r - 1, 0, win.mc));
            else
            begin
                tl = win.tl;
                ml = win.ml;
                bl = win.bl;
                tc = win.tc;
                bc = win.bc;
                sx = -tl + above2 - 2 * ml + 2 * above1 - bl + lvl;
                sy = -tl - 2 * tc - above2 + bl + 2 * bc + lvl;
                o = border_res(r - 1, c - 1, win.mc);
                // int division truncates toward zero, then keep the low byte
                o.grad_x = 8'(sx / 4);
                o.grad_y = 8'(sy / 4);
                step_results.push_back(o);
            end
            if (c == w - 1)
                step_results.push_back(border_res(r - 1, c, above1));
        end
        if (r == 0 || r == h - 1)
            step_results.push_back(border_res(r, c, lvl));
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;

        win.tl = win.tc;
        win.ml = win.mc;
        win.bl = win.bc;
        win.tc = 8'(above2);
        win.mc = 8'(above1);
        win.bc = 8'(lvl);

        pos_col++;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h)
                pos_row = 0;
        end
    endtask

    task automatic push_pixel(input pix_t p, input bit typed, input res_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        pixels_sent++;
        sobel_predict(p);
        if (typed)
            results_due.push_back(want);
        else
            foreach (step_results[k])
                results_due.push_back(step_results[k]);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!more)
            cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            fw_set = val[FW_W-1:0];
        else
            fh_set = val[FH_W-1:0];
    endtask

    // block idle: nothing owed, and time for a result-free item to leave
    task automatic wait_quiet();
        pix_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP)
            @(posedge clk);
    endtask

    function automatic pix_t random_pixel();
        pix_t p;
        case ($urandom_range(3))
            0:       p = '0;
            1:       p = '1;
            default: p = pix_t'(24'($urandom));
        endcase
        return p;
    endfunction

    // Pixels until the position is back at the top left. A cut shrinks the
    // height (restart from row 0) or the width (rest of the row dropped).
    task automatic run_frame(input bit allow_cut);
        int cut;
        cut = allow_cut ? $urandom_range(5) : 9;
        do
        begin
            push_pixel(random_pixel(), 1'b0, '0);
            if (cut == 0 && pos_col == 0 && pos_row >= 3)
            begin
                wait_quiet();
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(3, pos_row)), 1'b0);
                cut = 9;
            end
            else if (cut == 1 && pos_col >= 3)
            begin
                wait_quiet();
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(3, pos_col)), 1'b0);
                cut = 9;
            end
        end
        while (pos_row != 0 || pos_col != 0);
    endtask

    function automatic step_t px_step(input int r, input int g, input int b);
        step_t s;
        s.kind  = STEP_PIXEL;
        s.px    = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
        s.value = '0;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    // row 0 after reset is all border: gray repeated, single result per item
    function automatic step_t known_step(input int r, input int g, input int b,
                                         input int col, input int lvl);
        step_t s;
        s                  = px_step(r, g, b);
        s.typed            = 1'b1;
        s.want             = border_res(0, col, lvl);
        s.want.last_of_run = 1'b1;
        return s;
    endfunction

    function automatic step_t reg_step(input step_kind_t kind, input int val);
        step_t s;
        s       = px_step(0, 0, 0);
        s.kind  = kind;
        s.value = CFG_DATA_W'(val);
        return s;
    endfunction

    always @(posedge clk)
    begin : watch_results
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (results_due.size() == 0)
                report_mismatch($sformatf("unexpected result row %0d col %0d",
                                          res.pix_row, res.pix_col));
            else
            begin
                want = results_due.pop_front();
                if (res.pix_row !== want.pix_row)
                    report_mismatch($sformatf("pix_row %0d, expected %0d",
                                              res.pix_row, want.pix_row));
                if (res.pix_col !== want.pix_col)
                    report_mismatch($sformatf("pix_col %0d, expected %0d",
                                              res.pix_col, want.pix_col));
                if (res.gray !== want.gray)
                    report_mismatch($sformatf("gray %0d, expected %0d at (%0d,%0d)",
                                              res.gray, want.gray, want.pix_row, want.pix_col));
                if (res.grad_x !== want.grad_x)
                    report_mismatch($sformatf("grad_x %0d, expected %0d at (%0d,%0d)",
                                              res.grad_x, want.grad_x, want.pix_row,
                                              want.pix_col));
                if (res.grad_y !== want.grad_y)
                    report_mismatch($sformatf("grad_y %0d, expected %0d at (%0d,%0d)",
                                              res.grad_y, want.grad_y, want.pix_row,
                                              want.pix_col));
                if (res.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b at (%0d,%0d)",
                                              res.last_of_run, want.last_of_run,
                                              want.pix_row, want.pix_col));
            end
        end
    end

    initial
    begin : stimulus
        int start;
        plan = '{
            // reset sizes 2048 x 1024: first row straight out
            known_step(0, 0, 0, 0, 0),
            known_step(255, 255, 255, 1, 255),
            known_step(255, 0, 0, 2, 76),
            known_step(0, 0, 255, 3, 29),
            // both sizes below range, width shrunk mid-row: jump to row 1
            reg_step(STEP_WIDTH, 2),
            reg_step(STEP_HEIGHT, 0),
            px_step(0, 255, 0),
            px_step(12, 200, 99),
            px_step(255, 255, 255),
            px_step(255, 255, 255),
            px_step(0, 0, 0),
            px_step(128, 64, 32),
            // height above range; dark left, bright right gives full-scale X
            reg_step(STEP_HEIGHT, 8191),
            px_step(0, 0, 0),
            px_step(0, 0, 0),
            px_step(255, 255, 255),
            px_step(0, 0, 0),
            px_step(0, 0, 0),
            px_step(255, 255, 255),
            px_step(0, 0, 0),
            px_step(0, 0, 0),
            px_step(255, 255, 255),
            // height cut below the current row: next item starts a frame
            reg_step(STEP_HEIGHT, 3)
        };

        send_idle_pct = 21;
        stall_pct     = 85;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            case (plan[i].kind)
                STEP_PIXEL:
                    push_pixel(plan[i].px, plan[i].typed, plan[i].want);
                STEP_WIDTH:
                begin
                    wait_quiet();
                    write_reg(CFG_FRAME_WIDTH, plan[i].value, 1'b0);
                end
                default:
                begin
                    wait_quiet();
                    write_reg(CFG_FRAME_HEIGHT, plan[i].value, 1'b0);
                end
            endcase
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 85 : 0;
            stall_pct     = (phase == 0) ? 85 : (phase == 1) ? 21 : 0;
            if (phase == 2)
            begin
                // width at full scale (bit 12 of the data is dropped): a stretch
                // of row 0, then the width is cut back to finish the frame
                if (pos_row != 0 || pos_col != 0)
                    run_frame(1'b1);
                wait_quiet();
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3), 1'b1);
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(13'h1FFF), 1'b0);
                repeat (12)
                    push_pixel(random_pixel(), 1'b0, '0);
                wait_quiet();
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(3, 9)), 1'b0);
            end
            start = pixels_sent;
            while (pixels_sent - start < PHASE_ITEMS)
            begin
                if (pos_row != 0 || pos_col != 0)
                    run_frame(1'b1);
                wait_quiet();
                write_reg(CFG_FRAME_HEIGHT,
                          CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(2)
                                                               : $urandom_range(3, 7)),
                          1'b1);
                write_reg(CFG_FRAME_WIDTH,
                          CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(2)
                                                               : $urandom_range(3, 9)),
                          1'b0);
                repeat ($urandom_range(1, 2))
                    run_frame(1'b1);
            end
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/gsg_pkg.sv
hw/rtl/gsg_ram.sv
hw/rtl/gsg_sobel.sv
hw/rtl/gray_sobel_gradient.sv
tb/gray_sobel_gradient_tb.sv
